@@ rtl/ffha_pkg.sv @@
package ffha_pkg;

  // Byte address space seen by the allocator (12-bit addresses).
  localparam int unsigned ADDR_SPACE = 4096;

  // Microcode step addresses.
  typedef enum logic [4:0] {
    ST_CLR    = 5'd0,
    ST_WAIT   = 5'd1,
    ST_DISP   = 5'd2,
    ST_A_CHK  = 5'd3,
    ST_A_LOAD = 5'd4,
    ST_A_EVAL = 5'd5,
    ST_A_J1   = 5'd6,
    ST_A_J2   = 5'd7,
    ST_A_J3   = 5'd8,
    ST_A_SKIP = 5'd9,
    ST_TAKE   = 5'd10,
    ST_FRESH  = 5'd11,
    ST_OOM    = 5'd12,
    ST_F_CHK  = 5'd13,
    ST_F_LOAD = 5'd14,
    ST_F_WR   = 5'd15,
    ST_EMIT   = 5'd16,
    ST_BACK   = 5'd17
  } step_t;

  // Jump conditions: jump to target when true, else fall through to step + 1.
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_REQ,
    C_FREE,
    C_P_OUT,
    C_FAIL,
    C_FIT,
    C_ZERO,
    C_FREE_BAD,
    C_CLR_MORE,
    C_OUT_BUSY
  } cond_t;

  // Heap write source.
  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_MAG,
    WR_REQ,
    WR_NEG
  } wr_sel_t;

  // Result register update.
  typedef enum logic [1:0] {
    RES_KEEP,
    RES_ADDR,
    RES_OOM
  } res_sel_t;

  typedef struct packed {
    cond_t    cond;
    step_t    target;
    logic     accept;  // request may be taken in this step
    logic     ld_h;    // latch header and its magnitude from RAM
    logic     eval;    // register fit / fresh / fail decision
    logic     skip;    // advance walk pointer past current block
    wr_sel_t  wr;
    res_sel_t res;
    logic     emit;    // load output register when it is free
  } ctl_t;

  // Status from the datapath used as jump conditions.
  typedef struct packed {
    logic is_free;
    logic p_out;
    logic fail;
    logic fit;
    logic zero;
    logic free_bad;
    logic clr_more;
  } dp_flags_t;

  // Microcode ROM.
  function automatic ctl_t ucode(step_t s);
    ctl_t c;
    c = ctl_t'('0);
    case (s)
      ST_CLR: begin
        c.wr = WR_CLEAR; c.cond = C_CLR_MORE; c.target = ST_CLR;
      end
      ST_WAIT: begin
        c.accept = 1'b1; c.cond = C_NO_REQ; c.target = ST_WAIT;
      end
      ST_DISP: begin
        c.cond = C_FREE; c.target = ST_F_CHK;
      end
      ST_A_CHK: begin
        c.cond = C_P_OUT; c.target = ST_OOM;
      end
      ST_A_LOAD: begin
        c.ld_h = 1'b1;
      end
      ST_A_EVAL: begin
        c.eval = 1'b1;
      end
      ST_A_J1: begin
        c.cond = C_FAIL; c.target = ST_OOM;
      end
      ST_A_J2: begin
        c.cond = C_FIT; c.target = ST_TAKE;
      end
      ST_A_J3: begin
        c.cond = C_ZERO; c.target = ST_FRESH;
      end
      ST_A_SKIP: begin
        c.skip = 1'b1; c.cond = C_ALWAYS; c.target = ST_A_CHK;
      end
      ST_TAKE: begin
        c.wr = WR_MAG; c.res = RES_ADDR; c.cond = C_ALWAYS; c.target = ST_EMIT;
      end
      ST_FRESH: begin
        c.wr = WR_REQ; c.res = RES_ADDR; c.cond = C_ALWAYS; c.target = ST_EMIT;
      end
      ST_OOM: begin
        c.res = RES_OOM; c.cond = C_ALWAYS; c.target = ST_EMIT;
      end
      ST_F_CHK: begin
        c.cond = C_FREE_BAD; c.target = ST_EMIT;
      end
      ST_F_LOAD: begin
        c.ld_h = 1'b1;
      end
      ST_F_WR: begin
        c.wr = WR_NEG;
      end
      ST_EMIT: begin
        c.emit = 1'b1; c.cond = C_OUT_BUSY; c.target = ST_EMIT;
      end
      ST_BACK: begin
        c.cond = C_ALWAYS; c.target = ST_WAIT;
      end
      default: begin
        c.cond = C_ALWAYS; c.target = ST_CLR;
      end
    endcase
    return c;
  endfunction

endpackage

@@ rtl/ffha_ram.sv @@
module ffha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/ffha_seq.sv @@
// Microcode sequencer: step counter, ROM lookup, conditional jump.
module ffha_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_busy,
  input  ffha_pkg::dp_flags_t flags,
  output ffha_pkg::ctl_t      ctl
);

  ffha_pkg::step_t pc;
  ffha_pkg::step_t pc_next;
  logic            take;

  assign ctl = ffha_pkg::ucode(pc);

  always_comb begin
    case (ctl.cond)
      ffha_pkg::C_NONE:     take = 1'b0;
      ffha_pkg::C_ALWAYS:   take = 1'b1;
      ffha_pkg::C_NO_REQ:   take = !in_valid;
      ffha_pkg::C_FREE:     take = flags.is_free;
      ffha_pkg::C_P_OUT:    take = flags.p_out;
      ffha_pkg::C_FAIL:     take = flags.fail;
      ffha_pkg::C_FIT:      take = flags.fit;
      ffha_pkg::C_ZERO:     take = flags.zero;
      ffha_pkg::C_FREE_BAD: take = flags.free_bad;
      ffha_pkg::C_CLR_MORE: take = flags.clr_more;
      ffha_pkg::C_OUT_BUSY: take = out_busy;
      default:              take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      pc_next = ctl.target;
    end else begin
      pc_next = ffha_pkg::step_t'(5'(pc + 5'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ffha_pkg::ST_CLR;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

@@ rtl/ffha_datapath.sv @@
// Allocator datapath: walk pointer, header registers, decision flags,
// clear counter and heap RAM port drive.
module ffha_datapath #(
  parameter int MEM_WORDS = 1024,
  localparam int AW = $clog2(MEM_WORDS)
) (
  input  logic                clk,
  input  logic                rst,
  input  ffha_pkg::ctl_t      ctl,
  input  logic                accept,
  input  logic                in_type,
  input  logic [12:0]         in_bytes,
  input  logic [11:0]         in_faddr,
  input  logic                cfg_we,
  input  logic [11:0]         cfg_data,
  output ffha_pkg::dp_flags_t flags,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [31:0]         ram_wdata,
  output logic [AW-1:0]       ram_raddr,
  input  logic [31:0]         ram_rdata,
  output logic [11:0]         res_addr,
  output logic                res_oom
);

  localparam logic [13:0] END_BYTES = 14'(MEM_WORDS * 4);
  localparam logic [13:0] SPACE     = 14'(ffha_pkg::ADDR_SPACE);

  logic [11:0]   heap_base;
  logic          is_free;
  logic          free_bad;
  logic [13:0]   req;
  logic [12:0]   p;
  logic [31:0]   h;
  logic [31:0]   mag;
  logic          fail;
  logic          fit;
  logic          zero;
  logic [13:0]   next_p;
  logic [AW-1:0] clr_cnt;
  logic          clr_more;

  logic [13:0] p_hdr_end;
  logic        mag_big;
  logic [12:0] ext_small;
  logic [13:0] extent;
  logic [13:0] reach;
  logic        fail_next;
  logic        fit_next;
  logic        zero_next;
  logic [9:0]  fa_word;

  assign fa_word   = in_faddr[11:2];
  assign p_hdr_end = {1'b0, p} + 14'd4;

  // Block size decision on the latched header.
  assign mag_big   = |mag[31:12];
  assign ext_small = ({1'b0, mag[11:0]} + 13'd3) & ~13'd3;
  assign zero_next = (h == 32'd0);
  assign extent    = zero_next ? req : {1'b0, ext_small};
  assign reach     = p_hdr_end + extent;
  assign fit_next  = h[31] && ((|mag[31:14]) || (mag[13:0] >= req));
  assign fail_next = (!zero_next && mag_big) || (reach > END_BYTES);

  assign clr_more = (clr_cnt != AW'(MEM_WORDS - 1));

  always_comb begin
    flags.is_free  = is_free;
    flags.p_out    = (p_hdr_end > END_BYTES) || (p_hdr_end >= SPACE);
    flags.fail     = fail;
    flags.fit      = fit;
    flags.zero     = zero;
    flags.free_bad = free_bad;
    flags.clr_more = clr_more;
  end

  assign ram_raddr = p[AW+1:2];

  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = p[AW+1:2];
    ram_wdata = 32'd0;
    case (ctl.wr)
      ffha_pkg::WR_NONE:  ram_we = 1'b0;
      ffha_pkg::WR_CLEAR: ram_waddr = clr_cnt;
      ffha_pkg::WR_MAG:   ram_wdata = mag;
      ffha_pkg::WR_REQ:   ram_wdata = {18'd0, req};
      ffha_pkg::WR_NEG:   ram_wdata = 32'd0 - h;
      default:            ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
      clr_cnt   <= '0;
    end else begin
      if (cfg_we) begin
        heap_base <= cfg_data;
      end
      if (ctl.wr == ffha_pkg::WR_CLEAR) begin
        clr_cnt <= clr_more ? AW'(clr_cnt + 1'b1) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_free  <= in_type;
      req      <= ({1'b0, in_bytes} + 14'd3) & ~14'd3;
      free_bad <= (fa_word == 10'd0) || ({2'b00, fa_word, 2'b00} > END_BYTES);
      res_addr <= '0;
      res_oom  <= 1'b0;
      if (in_type) begin
        p <= {1'b0, 10'(fa_word - 10'd1), 2'b00};
      end else begin
        p <= {1'b0, heap_base[11:2], 2'b00};
      end
    end else begin
      if (ctl.skip) begin
        p <= next_p[12:0];
      end
      case (ctl.res)
        ffha_pkg::RES_ADDR: res_addr <= p_hdr_end[11:0];
        ffha_pkg::RES_OOM:  res_oom  <= 1'b1;
        default:            ;
      endcase
    end
    if (ctl.ld_h) begin
      h   <= ram_rdata;
      mag <= ram_rdata[31] ? (32'd0 - ram_rdata) : ram_rdata;
    end
    if (ctl.eval) begin
      fail   <= fail_next;
      fit    <= fit_next;
      zero   <= zero_next;
      next_p <= reach;
    end
  end

endmodule

@@ rtl/first_fit_heap_allocator_unit.sv @@
// First-fit heap allocator with an implicit free list.
//
// Requests arrive on the s_axis channel: tuser selects allocate (0) or
// free (1), tdata carries the byte count to allocate and the payload address
// to free. Each request yields exactly one result on m_axis: the payload
// address of the allocated block (zero on free or failure) and an
// out-of-memory flag. heap_base is written through cfg_wr_en / cfg_wr_data; the user
// must do so only while no request is in flight (the block does not enforce it).
//
// Sequence from acceptance to m_axis_tvalid: a free checks the address, reads the
// header and writes it negated (a rejected address goes straight to the result).
// An allocate reads, decides and advances per header it skips, then claims or fails
// and reports. One request is in flight at a time; the next waits for the back step.
//
// Reset: rst (synchronous) starts a clearing pass over all MEM_WORDS heap
// words with s_axis_tready low; configuration writes are taken throughout. A
// stalled m_axis holds its result; the next request is still accepted and
// processed, and its result waits for the register.
module first_fit_heap_allocator_unit #(
  parameter int HEAP_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,    // heap_base
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [12:0] alloc_bytes, [24:13] free_addr, rest zero
  input  logic        s_axis_tuser,   // [0] req_type
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [11:0] block_addr, [12] status, rest zero
);

  // Only the first 4 KB of the heap is addressable.
  localparam int MEM_WORDS = (HEAP_WORDS > ffha_pkg::ADDR_SPACE / 4) ?
                             ffha_pkg::ADDR_SPACE / 4 : HEAP_WORDS;
  localparam int AW = $clog2(MEM_WORDS);

  ffha_pkg::ctl_t      ctl;
  ffha_pkg::dp_flags_t flags;

  logic          accept;
  logic          out_busy;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;
  logic [11:0]   res_addr;
  logic          res_oom;

  assign s_axis_tready = ctl.accept;
  assign accept        = s_axis_tvalid && ctl.accept;
  assign out_busy      = m_axis_tvalid && !m_axis_tready;

  ffha_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .out_busy (out_busy),
    .flags    (flags),
    .ctl      (ctl)
  );

  ffha_datapath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .accept    (accept),
    .in_type   (s_axis_tuser),
    .in_bytes  (s_axis_tdata[12:0]),
    .in_faddr  (s_axis_tdata[24:13]),
    .cfg_we    (cfg_wr_en),
    .cfg_data  (cfg_wr_data),
    .flags     (flags),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_addr  (res_addr),
    .res_oom   (res_oom)
  );

  // Heap storage: one header/payload word per entry.
  ffha_ram #(
    .WIDTH (32),
    .DEPTH (MEM_WORDS)
  ) u_heap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register; the emit step loads it only once it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctl.emit && !out_busy) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit && !out_busy) begin
      m_axis_tdata <= {3'b000, res_oom, res_addr};
    end
  end

endmodule
